FILE: rtl/asd_pkg.sv
// Shared constants and types for the AND-gate section decoder.
package asd_pkg;

  // Default literal width and the fixed widths of the ports.
  localparam int unsigned LiteralWidthDefault = 32;
  localparam int unsigned OutWidth            = 32;
  localparam int unsigned IndexWidth          = 31;
  localparam int unsigned ByteWidth           = 8;
  localparam int unsigned CfgIndexWidth       = 2;
  localparam int unsigned CfgDataWidth        = 32;

  // Packed number format: seven payload bits, bit seven marks a continuation.
  localparam int unsigned GroupBits = 7;
  localparam int unsigned ContBit   = 7;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CfgFirstGateIndex = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgGateCount      = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [IndexWidth-1:0] FirstGateIndexReset = 31'd1;
  localparam logic [IndexWidth-1:0] GateCountReset      = 31'd0;

  // Side information that travels with each completed number.
  typedef struct packed {
    logic ovf;     // the number had set bits beyond the literal width
    logic second;  // the number is the second delta of its gate
    logic last;    // the number closes the final gate of the section
  } num_flags_t;

endpackage

FILE: rtl/asd_front.sv
// Front part: joins 7-bit groups into numbers and tags them per gate.
module asd_front #(
  parameter int unsigned LiteralWidth = asd_pkg::LiteralWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [asd_pkg::IndexWidth-1:0]  gate_count_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [asd_pkg::ByteWidth-1:0]   data_byte_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output logic [LiteralWidth-1:0]         push_value_o,
  output asd_pkg::num_flags_t             push_flags_o
);

  localparam int unsigned MaxGroups = (LiteralWidth + asd_pkg::GroupBits - 1) /
                                      asd_pkg::GroupBits;
  localparam int unsigned GposW     = $clog2(MaxGroups + 1);
  localparam int unsigned ShW       = $clog2(MaxGroups * asd_pkg::GroupBits + 1);
  localparam int unsigned WideW     = LiteralWidth + asd_pkg::GroupBits;

  logic [LiteralWidth-1:0]        acc_q, acc_d;
  logic [GposW-1:0]               gpos_q, gpos_d;
  logic                           ovf_q, ovf_d;
  logic                           phase_q, phase_d;
  logic [asd_pkg::IndexWidth-1:0] rem_q, rem_d;

  logic [asd_pkg::GroupBits-1:0]  payload;
  logic [ShW-1:0]                 shift;
  logic [WideW-1:0]               wide;
  logic                           grp_ovf;
  logic [LiteralWidth-1:0]        acc_new;
  logic                           in_fire;
  logic                           active;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign active     = (rem_q != '0);

  // Place the payload of this beat at its group position.
  assign payload = data_byte_i[asd_pkg::GroupBits-1:0];
  assign shift   = ShW'(gpos_q) * ShW'(asd_pkg::GroupBits);
  assign wide    = WideW'(payload) << shift;
  assign grp_ovf = (shift >= ShW'(LiteralWidth)) ? (payload != '0)
                                                 : (wide[WideW-1:LiteralWidth] != '0);
  assign acc_new = acc_q | wide[LiteralWidth-1:0];

  // Completed numbers go to the queue together with their gate tags.
  assign push_o             = in_fire && active && !data_byte_i[asd_pkg::ContBit];
  assign push_value_o       = acc_new;
  assign push_flags_o.ovf    = ovf_q | grp_ovf;
  assign push_flags_o.second = phase_q;
  assign push_flags_o.last   = phase_q && (rem_q == asd_pkg::IndexWidth'(1));

  // Group assembly and section bookkeeping.
  always_comb begin
    acc_d   = acc_q;
    gpos_d  = gpos_q;
    ovf_d   = ovf_q;
    phase_d = phase_q;
    rem_d   = rem_q;
    if (restart_i) begin
      acc_d   = '0;
      gpos_d  = '0;
      ovf_d   = 1'b0;
      phase_d = 1'b0;
      rem_d   = gate_count_i;
    end else if (in_fire && active) begin
      if (data_byte_i[asd_pkg::ContBit]) begin
        acc_d = acc_new;
        ovf_d = ovf_q | grp_ovf;
        if (gpos_q < GposW'(MaxGroups)) begin
          gpos_d = gpos_q + GposW'(1);
        end
      end else begin
        acc_d   = '0;
        gpos_d  = '0;
        ovf_d   = 1'b0;
        phase_d = !phase_q;
        if (phase_q) begin
          rem_d = rem_q - asd_pkg::IndexWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      gpos_q  <= '0;
      ovf_q   <= 1'b0;
      phase_q <= 1'b0;
      rem_q   <= asd_pkg::GateCountReset;
    end else begin
      acc_q   <= acc_d;
      gpos_q  <= gpos_d;
      ovf_q   <= ovf_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

endmodule

FILE: rtl/asd_queue.sv
// Short first-in first-out queue between the front and back parts.
module asd_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = asd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output logic [Width-1:0] head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (clr_i) begin
      wr_d  = '0;
      rd_d  = '0;
      cnt_d = '0;
    end else begin
      if (push_i) begin
        wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_d = cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i && !clr_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/asd_back.sv
// Back part: turns delta pairs into gate, left and right literals.
module asd_back #(
  parameter int unsigned LiteralWidth = asd_pkg::LiteralWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [asd_pkg::IndexWidth-1:0]  first_index_i,
  input  logic                            q_valid_i,
  input  logic [LiteralWidth-1:0]         q_value_i,
  input  asd_pkg::num_flags_t             q_flags_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [asd_pkg::OutWidth-1:0]    gate_literal_o,
  output logic [asd_pkg::OutWidth-1:0]    left_literal_o,
  output logic [asd_pkg::OutWidth-1:0]    right_literal_o,
  output logic                            bad_delta_o,
  output logic                            overflow_o,
  output logic                            last_gate_o
);

  localparam int unsigned OW   = asd_pkg::OutWidth;
  localparam int unsigned ExtW = (LiteralWidth > OW) ? LiteralWidth : OW;

  logic [asd_pkg::IndexWidth-1:0] idx_q, idx_d;
  logic [LiteralWidth-1:0]        held_q, held_d;
  logic                           bad_q, bad_d;
  logic                           ovf_q, ovf_d;

  logic                           out_valid_q, out_valid_d;
  logic [OW-1:0]                  gate_q, gate_d, left_q, left_d, right_q, right_d;
  logic                           obad_q, obad_d, oovf_q, oovf_d, olast_q, olast_d;

  logic [OW-1:0]                  gate_full;
  logic [LiteralWidth-1:0]        gate_lw;
  logic                           gate_ovf;
  logic [LiteralWidth-1:0]        left_new;
  logic [LiteralWidth-1:0]        right_new;
  logic                           out_free;

  // Gate literal at the literal width, with its own overflow check.
  assign gate_full = {idx_q, 1'b0};
  assign gate_lw   = LiteralWidth'(ExtW'(gate_full));
  assign gate_ovf  = ((gate_full >> LiteralWidth) != '0);

  assign left_new  = gate_lw - q_value_i;
  assign right_new = held_q - q_value_i;

  // A first delta never waits; a second one needs room in the output register.
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = q_valid_i && (!q_flags_i.second || out_free);

  always_comb begin
    idx_d       = idx_q;
    held_d      = held_q;
    bad_d       = bad_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    gate_d      = gate_q;
    left_d      = left_q;
    right_d     = right_q;
    obad_d      = obad_q;
    oovf_d      = oovf_q;
    olast_d     = olast_q;
    if (restart_i) begin
      idx_d       = first_index_i;
      held_d      = '0;
      bad_d       = 1'b0;
      ovf_d       = 1'b0;
      out_valid_d = 1'b0;
    end else if (pop_o) begin
      if (!q_flags_i.second) begin
        // First delta: form the left literal and hold it.
        held_d = left_new;
        bad_d  = bad_q | (q_value_i == '0) | (q_value_i > gate_lw);
        ovf_d  = ovf_q | q_flags_i.ovf | gate_ovf;
      end else begin
        // Second delta: finish the gate and load the output register.
        out_valid_d = 1'b1;
        gate_d      = OW'(ExtW'(gate_lw));
        left_d      = OW'(ExtW'(held_q));
        right_d     = OW'(ExtW'(right_new));
        obad_d      = bad_q | (q_value_i > held_q);
        oovf_d      = ovf_q | q_flags_i.ovf | gate_ovf;
        olast_d     = q_flags_i.last;
        held_d      = '0;
        bad_d       = 1'b0;
        ovf_d       = 1'b0;
        idx_d       = idx_q + asd_pkg::IndexWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= asd_pkg::FirstGateIndexReset;
      held_q      <= '0;
      bad_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      held_q      <= held_d;
      bad_q       <= bad_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    gate_q  <= gate_d;
    left_q  <= left_d;
    right_q <= right_d;
    obad_q  <= obad_d;
    oovf_q  <= oovf_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = out_valid_q;
  assign gate_literal_o  = gate_q;
  assign left_literal_o  = left_q;
  assign right_literal_o = right_q;
  assign bad_delta_o     = obad_q;
  assign overflow_o      = oovf_q;
  assign last_gate_o     = olast_q;

endmodule

FILE: rtl/aig_and_section_decoder.sv
// Top level of the AND-gate section decoder.
//
//   Channel  Direction  Handshake                Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o    data_byte_i
//   out      out        out_valid_o/out_ready_i  gate/left/right literal, flags
//
// One byte beat is taken per cycle. The number that ends a gate's second delta is
// pushed into the queue, then popped into the output register. A two-entry queue
// sits between the byte assembler and the literal unit, so input beats keep
// flowing while the output register waits; input stalls only when that queue is
// full. Reset needs no clearing pass; a write of gate_count restarts decoding at once.
module aig_and_section_decoder #(
  parameter int unsigned LiteralWidth = asd_pkg::LiteralWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [asd_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [asd_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [asd_pkg::ByteWidth-1:0]      data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [asd_pkg::OutWidth-1:0]       gate_literal_o,
  output logic [asd_pkg::OutWidth-1:0]       left_literal_o,
  output logic [asd_pkg::OutWidth-1:0]       right_literal_o,
  output logic                               bad_delta_o,
  output logic                               overflow_o,
  output logic                               last_gate_o
);

  localparam int unsigned EntryW = LiteralWidth + $bits(asd_pkg::num_flags_t);

  logic [asd_pkg::IndexWidth-1:0] first_idx_q, first_idx_d;
  logic                           cfg_fire;
  logic                           restart;

  logic                           push, pop, q_valid, q_full;
  logic [LiteralWidth-1:0]        push_value, head_value;
  asd_pkg::num_flags_t            push_flags, head_flags;
  logic [EntryW-1:0]              head_entry;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_fire && (cfg_index_i == asd_pkg::CfgGateCount);

  always_comb begin
    first_idx_d = first_idx_q;
    if (cfg_fire && (cfg_index_i == asd_pkg::CfgFirstGateIndex)) begin
      first_idx_d = cfg_data_i[asd_pkg::IndexWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_idx_q <= asd_pkg::FirstGateIndexReset;
    end else begin
      first_idx_q <= first_idx_d;
    end
  end

  // Byte assembler.
  asd_front #(
    .LiteralWidth (LiteralWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .gate_count_i (cfg_data_i[asd_pkg::IndexWidth-1:0]),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_value_o (push_value),
    .push_flags_o (push_flags)
  );

  // Queue of completed numbers.
  asd_queue #(
    .Width (EntryW),
    .Depth (asd_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (restart),
    .push_i      (push),
    .push_data_i ({push_value, push_flags}),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .full_o      (q_full),
    .head_o      (head_entry)
  );

  assign head_value = head_entry[EntryW-1:$bits(asd_pkg::num_flags_t)];
  assign head_flags = head_entry[$bits(asd_pkg::num_flags_t)-1:0];

  // Literal unit and output register.
  asd_back #(
    .LiteralWidth (LiteralWidth)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (restart),
    .first_index_i   (first_idx_q),
    .q_valid_i       (q_valid),
    .q_value_i       (head_value),
    .q_flags_i       (head_flags),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .gate_literal_o  (gate_literal_o),
    .left_literal_o  (left_literal_o),
    .right_literal_o (right_literal_o),
    .bad_delta_o     (bad_delta_o),
    .overflow_o      (overflow_o),
    .last_gate_o     (last_gate_o)
  );

endmodule
